@@ rtl/core/bfc_pkg.sv @@
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the bus frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

    // Result status codes
    localparam logic [2:0] STS_FWD     = 3'd0;
    localparam logic [2:0] STS_PARITY  = 3'd1;
    localparam logic [2:0] STS_XOR     = 3'd2;
    localparam logic [2:0] STS_MASTER  = 3'd3;
    localparam logic [2:0] STS_TIMEOUT = 3'd4;

    // Request kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Frame format
    localparam logic [3:0] LEN_MASK       = 4'hF;
    localparam logic [4:0] FRAME_OVERHEAD = 5'd3;
    localparam logic [4:0] MAX_FRAME_LEN  = 5'd18;
    localparam logic [1:0] ROLE_MASK      = 2'b11;
    localparam logic [1:0] ROLE_MASTER    = 2'b01;

    localparam logic [7:0] TIMEOUT_RESET  = 8'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } bfc_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept_en;   // input requests may be taken
        logic rd_issue;    // read frame store at replay index
        logic rep_load;    // move read data to output register
    } bfc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;      // output register empty or draining
        logic replay_start;  // good frame accepted, replay it
        logic rep_last;      // replay index at final byte
    } bfc_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/bfc_datapath.sv @@
// ----------------------------------------------------------------------------
// bfc_datapath
// Frame store, counters, checks and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_datapath #(
    parameter int FRAME_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             cmd,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic [2:0]            status,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata,
    input  wire bfc_pkg::bfc_cmd_t ctl,
    output bfc_pkg::bfc_sts_t     sts
);

    localparam int AW = $clog2(FRAME_DEPTH);

    logic [7:0] mem [FRAME_DEPTH];
    logic [7:0] mem_q_reg;

    logic [4:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] idle_reg, idle_next;
    logic [7:0] timeout_reg;
    logic [7:0] call_reg;
    logic [3:0] hdr_reg;
    logic [4:0] rep_len_reg, rep_len_next;
    logic [4:0] rep_idx_reg, rep_idx_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic [2:0] out_sts_reg, out_sts_next;

    logic       in_fire;
    logic       byte_fire;
    logic       res_load;
    logic       replay_start;
    logic [4:0] cnt_inc;
    logic [7:0] xor_acc;
    logic [4:0] frame_len;
    logic [7:0] idle_sat;
    logic       frame_done;

    assign in_fire   = in_valid && ctl.accept_en;
    assign byte_fire = in_fire && (cmd == bfc_pkg::CMD_BYTE);
    assign cnt_inc   = count_reg + 5'd1;
    assign xor_acc   = (count_reg != 5'd0) ? (xor_reg ^ rx_byte) : xor_reg;
    assign frame_len = {1'b0, hdr_reg & bfc_pkg::LEN_MASK} + bfc_pkg::FRAME_OVERHEAD;
    assign idle_sat  = (idle_reg < timeout_reg) ? (idle_reg + 8'd1) : idle_reg;
    assign frame_done = (cnt_inc >= bfc_pkg::FRAME_OVERHEAD) && (cnt_inc >= frame_len);

    always_comb
    begin
        count_next     = count_reg;
        xor_next       = xor_reg;
        idle_next      = idle_reg;
        rep_len_next   = rep_len_reg;
        rep_idx_next   = rep_idx_reg;
        res_load       = 1'b0;
        replay_start   = 1'b0;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_sts_next   = out_sts_reg;

        if (in_fire && (cmd == bfc_pkg::CMD_TICK))
        begin
            idle_next = idle_sat;
            if ((idle_sat >= timeout_reg) && (count_reg != 5'd0))
            begin
                count_next    = 5'd0;
                xor_next      = 8'd0;
                idle_next     = 8'd0;
                res_load      = 1'b1;
                out_byte_next = 8'd0;
                out_last_next = 1'b1;
                out_sts_next  = bfc_pkg::STS_TIMEOUT;
            end
        end
        else if (byte_fire)
        begin
            idle_next  = 8'd0;
            count_next = cnt_inc;
            xor_next   = xor_acc;
            if (frame_done)
            begin
                count_next    = 5'd0;
                xor_next      = 8'd0;
                out_byte_next = 8'd0;
                out_last_next = 1'b1;
                priority if (^call_reg)
                begin
                    res_load     = 1'b1;
                    out_sts_next = bfc_pkg::STS_PARITY;
                end
                else if (xor_acc != 8'd0)
                begin
                    res_load     = 1'b1;
                    out_sts_next = bfc_pkg::STS_XOR;
                end
                else if ((call_reg[6:5] & bfc_pkg::ROLE_MASK) == bfc_pkg::ROLE_MASTER)
                begin
                    res_load     = 1'b1;
                    out_sts_next = bfc_pkg::STS_MASTER;
                end
                else
                begin
                    replay_start = 1'b1;
                    rep_len_next = frame_len;
                    rep_idx_next = 5'd0;
                end
            end
        end

        if (ctl.rep_load)
        begin
            out_byte_next = mem_q_reg;
            out_last_next = sts.rep_last;
            out_sts_next  = bfc_pkg::STS_FWD;
            rep_idx_next  = rep_idx_reg + 5'd1;
        end
    end

    // Output register: load wins over drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (res_load || ctl.rep_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 5'd0;
            xor_reg       <= 8'd0;
            idle_reg      <= 8'd0;
            timeout_reg   <= bfc_pkg::TIMEOUT_RESET;
            rep_len_reg   <= 5'd0;
            rep_idx_reg   <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            xor_reg       <= xor_next;
            idle_reg      <= idle_next;
            rep_len_reg   <= rep_len_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                timeout_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_sts_reg  <= out_sts_next;
        if (byte_fire && (count_reg == 5'd0))
            call_reg <= rx_byte;
        if (byte_fire && (count_reg == 5'd1))
            hdr_reg <= rx_byte[3:0];
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (byte_fire)
            mem[AW'(count_reg)] <= rx_byte;
        if (ctl.rd_issue)
            mem_q_reg <= mem[AW'(rep_idx_reg)];
    end

    assign sts.out_free     = !out_valid_reg || !out_stall;
    assign sts.replay_start = replay_start;
    assign sts.rep_last     = ((rep_idx_reg + 5'd1) == rep_len_reg);

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign status      = out_sts_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < bfc_pkg::MAX_FRAME_LEN)
        else $error("frame byte count beyond longest frame");

    a_replay_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sts.replay_start |=> (count_reg == 5'd0) && (xor_reg == 8'd0))
        else $error("frame state not cleared after good frame");

    a_replay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rep_load |-> (rep_idx_reg < rep_len_reg))
        else $error("replay index past frame length");

endmodule

`default_nettype wire

@@ rtl/core/bfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: request intake and byte-by-byte replay of a good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bfc_pkg::bfc_sts_t sts,
    output bfc_pkg::bfc_cmd_t      ctl
);

    bfc_pkg::bfc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bfc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfc_pkg::S_IDLE:
            begin
                if (sts.replay_start)
                    state_next = bfc_pkg::S_RD;
            end
            bfc_pkg::S_RD:
                state_next = bfc_pkg::S_WR;
            bfc_pkg::S_WR:
            begin
                if (sts.out_free)
                    state_next = sts.rep_last ? bfc_pkg::S_IDLE : bfc_pkg::S_RD;
            end
            default:
                state_next = bfc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            bfc_pkg::S_IDLE:
                ctl.accept_en = sts.out_free;
            bfc_pkg::S_RD:
                ctl.rd_issue = 1'b1;
            bfc_pkg::S_WR:
                ctl.rep_load = sts.out_free;
            default:
                ctl = '0;
        endcase
    end

    a_start_reads: assert property (@(posedge clk) disable iff (!rst_n)
        sts.replay_start |=> (state_reg == bfc_pkg::S_RD))
        else $error("replay did not start");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfc_pkg::S_RD) |=> (state_reg == bfc_pkg::S_WR))
        else $error("read not followed by load");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rep_load && sts.rep_last |=> (state_reg == bfc_pkg::S_IDLE))
        else $error("replay ran past final byte");

endmodule

`default_nettype wire

@@ rtl/core/bus_frame_checker.sv @@
// ----------------------------------------------------------------------------
// bus_frame_checker
// Host frame checker with call-byte parity and XOR check byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): each request is a received byte
// (cmd = 0) or one timeout tick (cmd = 1). A frame is a call byte, a header,
// (header & 0xF) data bytes and an XOR byte, 3 to 18 bytes in all.
// Output channel (out_valid/out_stall): one result register. A bad, master
// or timed-out frame gives one status-only result, visible the cycle after
// the completing request. A good frame is replayed from the frame store:
// each byte is a store read, then an output load that waits while the result
// register is full and stalled; last_of_run marks the final byte.
// Throughput: one request per cycle while idle and results drain; a replay
// holds off input until its final byte is loaded. Input is also held while
// the result register is full and stalled.
// cfg_we/cfg_wdata write the idle-tick limit; write only while quiet.
// Reset: counters and XOR cleared, limit = 10, output empty. The frame store
// is not cleared; each entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_frame_checker #(
    parameter int FRAME_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       cmd,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic [2:0]      status,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    bfc_pkg::bfc_cmd_t ctl;
    bfc_pkg::bfc_sts_t sts;

    bfc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    bfc_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ctl         (ctl),
        .sts         (sts)
    );

    // Requests only taken in idle with room in the result register
    assign in_stall = !ctl.accept_en;

endmodule

`default_nettype wire
